@@ design/hcvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcvs_pkg
// Shared types and constants for the high-degree cycle vertex search core.
// ----------------------------------------------------------------------------
package hcvs_pkg;

   localparam int MaxVertices = 64;
   localparam int VIdxW       = $clog2(MaxVertices);
   localparam int CntW        = $clog2(MaxVertices + 1);
   localparam int FieldW      = 7;
   localparam int DegW        = 3;

   localparam logic [DegW-1:0]   DegCap           = DegW'(4);
   localparam logic [CntW-1:0]   SizeFloor        = CntW'(2);
   localparam logic [FieldW-1:0] VertexCountReset = FieldW'(64);

   // input beat
   typedef struct packed {
      logic [FieldW-1:0] from_vertex;
      logic [FieldW-1:0] to_vertex;
      logic              last_edge;
   } req_type;

   // result beat
   typedef struct packed {
      logic              found;
      logic [FieldW-1:0] vertex;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERD_U,
      S_EWR_U,
      S_ERD_V,
      S_EWR_V,
      S_OUTER,
      S_ROW_WAIT,
      S_SCAN,
      S_CMP,
      S_DONE,
      S_POP_RD,
      S_POP_WR,
      S_RET,
      S_RESTORE,
      S_FIN,
      S_EMIT
   } state_type;

   // adjacency / degree store commands
   typedef struct packed {
      logic                   rd_en;
      logic [VIdxW-1:0]       rd_addr;
      logic                   wr_en;
      logic [VIdxW-1:0]       wr_addr;
      logic [MaxVertices-1:0] wr_row;
      logic [DegW-1:0]        wr_deg;
      logic                   clear;
   } adj_cmd_type;

   // one frame of the depth-first walk
   typedef struct packed {
      logic [VIdxW-1:0] vertex;
      logic [VIdxW-1:0] parent;
      logic [CntW-1:0]  next;
      logic [CntW-1:0]  low;
      logic [CntW-1:0]  order;
      logic [VIdxW-1:0] pend;
   } frame_type;

   // walk stack, pending stack and visit order memory commands
   typedef struct packed {
      logic             ws_wr;
      logic [VIdxW-1:0] ws_waddr;
      frame_type        ws_wdata;
      logic [VIdxW-1:0] ws_raddr;
      logic             pd_wr;
      logic [VIdxW-1:0] pd_waddr;
      logic [VIdxW-1:0] pd_wdata;
      logic [VIdxW-1:0] pd_raddr;
      logic             vo_wr;
      logic [VIdxW-1:0] vo_waddr;
      logic [CntW-1:0]  vo_wdata;
      logic [VIdxW-1:0] vo_raddr;
   } stk_cmd_type;

   typedef struct packed {
      frame_type        ws_rdata;
      logic [VIdxW-1:0] pd_rdata;
      logic [CntW-1:0]  vo_rdata;
   } stk_rsp_type;

endpackage

@@ design/hcvs_adj_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcvs_adj_store
// Adjacency row memory with the saturating degree count kept beside each
// row. Row valid bits make a cleared row read as zero.
// ----------------------------------------------------------------------------
module hcvs_adj_store (
   input  logic                                clock,
   input  logic                                reset,
   input  hcvs_pkg::adj_cmd_type               cmd,
   output logic [hcvs_pkg::MaxVertices-1:0]    rd_row,
   output logic [hcvs_pkg::DegW-1:0]           rd_deg
);
   import hcvs_pkg::*;

   logic [DegW+MaxVertices-1:0] mem [MaxVertices];
   logic [DegW+MaxVertices-1:0] rdata_ff;
   logic [MaxVertices-1:0]      valid_ff;
   logic                        rvalid_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= {cmd.wr_deg, cmd.wr_row};
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.rd_addr];
      end
   end

   // row valid bits
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (cmd.rd_en) begin
         rvalid_ff <= valid_ff[cmd.rd_addr] && !(cmd.wr_en && cmd.clear);
      end
   end

   assign rd_row = rvalid_ff ? rdata_ff[MaxVertices-1:0] : '0;
   assign rd_deg = rvalid_ff ? rdata_ff[DegW+MaxVertices-1:MaxVertices] : '0;

endmodule

@@ design/hcvs_walk_stacks.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcvs_walk_stacks
// Walk frame stack, pending vertex stack and visit order memory of the
// depth-first search. Each is read every cycle with registered data.
// ----------------------------------------------------------------------------
module hcvs_walk_stacks (
   input  logic                  clock,
   input  hcvs_pkg::stk_cmd_type cmd,
   output hcvs_pkg::stk_rsp_type rsp
);
   import hcvs_pkg::*;

   frame_type        walk_mem  [MaxVertices];
   logic [VIdxW-1:0] pend_mem  [MaxVertices];
   logic [CntW-1:0]  order_mem [MaxVertices];

   // walk frames
   always_ff @(posedge clock) begin
      if (cmd.ws_wr) begin
         walk_mem[cmd.ws_waddr] <= cmd.ws_wdata;
      end
      rsp.ws_rdata <= walk_mem[cmd.ws_raddr];
   end

   // pending vertices
   always_ff @(posedge clock) begin
      if (cmd.pd_wr) begin
         pend_mem[cmd.pd_waddr] <= cmd.pd_wdata;
      end
      rsp.pd_rdata <= pend_mem[cmd.pd_raddr];
   end

   // visit order numbers
   always_ff @(posedge clock) begin
      if (cmd.vo_wr) begin
         order_mem[cmd.vo_waddr] <= cmd.vo_wdata;
      end
      rsp.vo_rdata <= order_mem[cmd.vo_raddr];
   end

endmodule

@@ design/high_degree_cycle_vertex_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// high_degree_cycle_vertex_search_core
// Edge loader, depth-first bridge-free component search and result scan.
// ----------------------------------------------------------------------------
// Edges arrive one per beat. An edge with both endpoints in range is loaded
// by a read-modify-write of two rows on the single adjacency port (states
// ERD_U, EWR_U, ERD_V, EWR_V); after an out-of-range edge the core is ready
// again in the next cycle. The beat marked last starts the search, which
// visits one adjacency column per cycle for every vertex, unless a compare
// for an edge to a vertex still on the pending stack holds it, plus the
// entry, return and component pop steps of each vertex, and a final scan of
// one vertex per cycle. The core is not ready during the load of an edge,
// the search, or while a new result waits for the output register. A result
// waits in an output register and does not block the next graph's edges.
// Adjacency store and search state clear in the cycle the result is issued.
// ----------------------------------------------------------------------------
module high_degree_cycle_vertex_search_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hcvs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hcvs_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [hcvs_pkg::FieldW-1:0]     csr_wr_data
);
   import hcvs_pkg::*;

   state_type              state_ff, state_in;
   logic [FieldW-1:0]      csr_ff;
   logic [FieldW-1:0]      u_ff, u_in, v_ff, v_in;
   logic                   last_ff, last_in;
   logic [MaxVertices-1:0] row_ff, row_in;
   frame_type              top_ff, top_in;
   logic [CntW-1:0]        depth_ff, depth_in;
   logic [CntW-1:0]        pend_ptr_ff, pend_ptr_in;
   logic [CntW-1:0]        visit_cnt_ff, visit_cnt_in;
   logic [CntW-1:0]        root_ff, root_in;
   logic [MaxVertices-1:0] vis_ff, vis_in;
   logic [MaxVertices-1:0] onstk_ff, onstk_in;
   logic [MaxVertices-1:0] qual_ff, qual_in;
   logic [MaxVertices-1:0] deg4_ff, deg4_in;
   logic                   big_ff, big_in;
   logic [FieldW-1:0]      hit_ff, hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   adj_cmd_type            adj_cmd;
   logic [MaxVertices-1:0] adj_row;
   logic [DegW-1:0]        adj_deg;
   logic [DegW-1:0]        deg_next;
   stk_cmd_type            stk_cmd;
   stk_rsp_type            stk_rsp;

   logic [CntW-1:0]        n;
   logic [FieldW-1:0]      u_m1, v_m1;
   logic [VIdxW-1:0]       u_idx, v_idx, c_idx, w_idx, r_idx;
   logic                   in_range;
   logic                   do_enter, do_push;
   logic [VIdxW-1:0]       enter_v;
   logic [CntW-1:0]        cnt1;
   frame_type              pushed;

   hcvs_adj_store u_adj (
      .clock  (clock),
      .reset  (reset),
      .cmd    (adj_cmd),
      .rd_row (adj_row),
      .rd_deg (adj_deg)
   );

   hcvs_walk_stacks u_stk (
      .clock (clock),
      .cmd   (stk_cmd),
      .rsp   (stk_rsp)
   );

   // effective vertex count and edge indexes
   assign n     = (32'(csr_ff) > MaxVertices) ? CntW'(MaxVertices) : CntW'(csr_ff);
   assign u_m1  = u_ff - FieldW'(1);
   assign v_m1  = v_ff - FieldW'(1);
   assign u_idx = VIdxW'(u_m1);
   assign v_idx = VIdxW'(v_m1);
   assign c_idx = VIdxW'(top_ff.next);
   assign w_idx = stk_rsp.pd_rdata;
   assign r_idx = VIdxW'(root_ff);
   assign cnt1  = visit_cnt_ff + CntW'(1);
   assign deg_next = (adj_deg < DegCap) ? adj_deg + DegW'(1) : adj_deg;

   assign in_range = (req_data.from_vertex != '0) && (req_data.to_vertex != '0) &&
                     (32'(req_data.from_vertex) <= 32'(n)) &&
                     (32'(req_data.to_vertex) <= 32'(n));

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      row_in       = row_ff;
      top_in       = top_ff;
      depth_in     = depth_ff;
      pend_ptr_in  = pend_ptr_ff;
      visit_cnt_in = visit_cnt_ff;
      root_in      = root_ff;
      vis_in       = vis_ff;
      onstk_in     = onstk_ff;
      qual_in      = qual_ff;
      deg4_in      = deg4_ff;
      big_in       = big_ff;
      hit_in       = hit_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      do_enter     = 1'b0;
      do_push      = 1'b0;
      enter_v      = '0;
      pushed       = top_ff;
      pushed.next  = top_ff.next + CntW'(1);

      adj_cmd      = '0;
      stk_cmd      = '0;
      stk_cmd.ws_raddr = VIdxW'(depth_ff - CntW'(2));
      stk_cmd.pd_raddr = VIdxW'(pend_ptr_ff - CntW'(1));
      stk_cmd.vo_raddr = c_idx;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               u_in    = req_data.from_vertex;
               v_in    = req_data.to_vertex;
               last_in = req_data.last_edge;
               if (in_range) begin
                  state_in = S_ERD_U;
               end else if (req_data.last_edge) begin
                  state_in = S_OUTER;
               end
            end
         end
         // read-modify-write of both endpoint rows
         S_ERD_U: begin
            adj_cmd.rd_en   = 1'b1;
            adj_cmd.rd_addr = u_idx;
            state_in        = S_EWR_U;
         end
         S_EWR_U: begin
            adj_cmd.wr_en   = 1'b1;
            adj_cmd.wr_addr = u_idx;
            adj_cmd.wr_row  = adj_row | (MaxVertices'(1) << v_idx);
            adj_cmd.wr_deg  = deg_next;
            deg4_in[u_idx]  = (deg_next == DegCap);
            state_in        = S_ERD_V;
         end
         S_ERD_V: begin
            adj_cmd.rd_en   = 1'b1;
            adj_cmd.rd_addr = v_idx;
            state_in        = S_EWR_V;
         end
         S_EWR_V: begin
            adj_cmd.wr_en   = 1'b1;
            adj_cmd.wr_addr = v_idx;
            adj_cmd.wr_row  = adj_row | (MaxVertices'(1) << u_idx);
            adj_cmd.wr_deg  = deg_next;
            deg4_in[v_idx]  = (deg_next == DegCap);
            state_in        = last_ff ? S_OUTER : S_IDLE;
         end
         // pick the next unvisited root
         S_OUTER: begin
            if (root_ff >= n) begin
               root_in  = '0;
               state_in = S_FIN;
            end else if (vis_ff[r_idx]) begin
               root_in = root_ff + CntW'(1);
            end else begin
               do_enter = 1'b1;
               enter_v  = r_idx;
            end
         end
         // capture the row, dropping the tree edge back to the parent
         S_ROW_WAIT: begin
            if (depth_ff > CntW'(1)) begin
               row_in = adj_row & ~(MaxVertices'(1) << top_ff.parent);
            end else begin
               row_in = adj_row;
            end
            state_in = S_SCAN;
         end
         // one adjacency column per cycle, while no compare or child entry holds it
         S_SCAN: begin
            if (top_ff.next >= n) begin
               state_in = S_DONE;
            end else begin
               top_in.next = top_ff.next + CntW'(1);
               if (row_ff[c_idx]) begin
                  if (!vis_ff[c_idx]) begin
                     do_enter = 1'b1;
                     do_push  = 1'b1;
                     enter_v  = c_idx;
                  end else if (onstk_ff[c_idx]) begin
                     state_in = S_CMP;
                  end
               end
            end
         end
         S_CMP: begin
            if (stk_rsp.vo_rdata < top_ff.low) begin
               top_in.low = stk_rsp.vo_rdata;
            end
            state_in = S_SCAN;
         end
         S_DONE: begin
            if (top_ff.low == top_ff.order) begin
               big_in   = (pend_ptr_ff - CntW'(top_ff.pend)) > SizeFloor;
               state_in = S_POP_RD;
            end else begin
               state_in = S_RET;
            end
         end
         // pop the finished component
         S_POP_RD: begin
            state_in = S_POP_WR;
         end
         S_POP_WR: begin
            onstk_in[w_idx] = 1'b0;
            qual_in[w_idx]  = big_ff;
            pend_ptr_in     = pend_ptr_ff - CntW'(1);
            if (pend_ptr_ff - CntW'(1) == CntW'(top_ff.pend)) begin
               state_in = S_RET;
            end else begin
               state_in = S_POP_RD;
            end
         end
         S_RET: begin
            depth_in = depth_ff - CntW'(1);
            state_in = (depth_ff == CntW'(1)) ? S_OUTER : S_RESTORE;
         end
         // resume the parent frame with the child's low link folded in
         S_RESTORE: begin
            top_in = stk_rsp.ws_rdata;
            if (top_ff.low < stk_rsp.ws_rdata.low) begin
               top_in.low = top_ff.low;
            end
            adj_cmd.rd_en   = 1'b1;
            adj_cmd.rd_addr = stk_rsp.ws_rdata.vertex;
            state_in        = S_ROW_WAIT;
         end
         // lowest qualifying vertex
         S_FIN: begin
            if (root_ff >= n) begin
               hit_in   = '0;
               state_in = S_EMIT;
            end else if (deg4_ff[r_idx] && qual_ff[r_idx]) begin
               hit_in   = FieldW'(root_ff + CntW'(1));
               state_in = S_EMIT;
            end else begin
               root_in = root_ff + CntW'(1);
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.found  = (hit_ff != '0);
               rsp_data_in.vertex = hit_ff;
               adj_cmd.clear      = 1'b1;
               vis_in             = '0;
               onstk_in           = '0;
               qual_in            = '0;
               deg4_in            = '0;
               depth_in           = '0;
               pend_ptr_in        = '0;
               visit_cnt_in       = '0;
               root_in            = '0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // enter a vertex: number it, push it on the pending stack, fetch its row
      if (do_enter) begin
         visit_cnt_in      = cnt1;
         top_in.vertex     = enter_v;
         top_in.parent     = top_ff.vertex;
         top_in.next       = '0;
         top_in.low        = cnt1;
         top_in.order      = cnt1;
         top_in.pend       = VIdxW'(pend_ptr_ff);
         stk_cmd.vo_wr     = 1'b1;
         stk_cmd.vo_waddr  = enter_v;
         stk_cmd.vo_wdata  = cnt1;
         stk_cmd.pd_wr     = 1'b1;
         stk_cmd.pd_waddr  = VIdxW'(pend_ptr_ff);
         stk_cmd.pd_wdata  = enter_v;
         pend_ptr_in       = pend_ptr_ff + CntW'(1);
         vis_in[enter_v]   = 1'b1;
         onstk_in[enter_v] = 1'b1;
         adj_cmd.rd_en     = 1'b1;
         adj_cmd.rd_addr   = enter_v;
         depth_in          = depth_ff + CntW'(1);
         state_in          = S_ROW_WAIT;
         if (do_push) begin
            stk_cmd.ws_wr    = 1'b1;
            stk_cmd.ws_waddr = VIdxW'(depth_ff - CntW'(1));
            stk_cmd.ws_wdata = pushed;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_ff       <= VertexCountReset;
         depth_ff     <= '0;
         pend_ptr_ff  <= '0;
         visit_cnt_ff <= '0;
         root_ff      <= '0;
         vis_ff       <= '0;
         onstk_ff     <= '0;
         qual_ff      <= '0;
         deg4_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         depth_ff     <= depth_in;
         pend_ptr_ff  <= pend_ptr_in;
         visit_cnt_ff <= visit_cnt_in;
         root_ff      <= root_in;
         vis_ff       <= vis_in;
         onstk_ff     <= onstk_in;
         qual_ff      <= qual_in;
         deg4_ff      <= deg4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      u_ff        <= u_in;
      v_ff        <= v_in;
      last_ff     <= last_in;
      row_ff      <= row_in;
      top_ff      <= top_in;
      big_ff      <= big_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // every frame on the walk stack has its vertex on the pending stack,
   // except in the return cycle after a component root has been popped
   a_pend_covers_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_RET) |-> (pend_ptr_ff >= depth_ff))
      else $error("pending stack shallower than walk stack");

   // the walk never numbers more vertices than exist
   a_visit_bound: assert property (@(posedge clock) disable iff (reset)
      visit_cnt_ff <= CntW'(MaxVertices))
      else $error("visit counter overflow");

   // stacks are empty whenever edges are being taken
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (depth_ff == '0 && pend_ptr_ff == '0 && vis_ff == '0))
      else $error("search state left behind after result");

   // a vertex on the pending stack has been visited
   a_onstk_visited: assert property (@(posedge clock) disable iff (reset)
      (onstk_ff & ~vis_ff) == '0)
      else $error("unvisited vertex marked on stack");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the high-degree cycle vertex search core.
// ----------------------------------------------------------------------------
// Graphs are streamed in edge by edge. A behavioral copy of the search runs
// on every accepted edge. When an edge is marked last, that copy walks the
// graph for its bridge-free components and queues the expected answer.
// Results are compared field by field as they leave the core. Both sides
// idle at random, and the result side is held off for a long stretch once.
// ----------------------------------------------------------------------------
module testbench;
   import hcvs_pkg::*;

   localparam int NV = MaxVertices;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [FieldW-1:0] csr_wr_data;

   // bench state
   rsp_type answer_q[$];
   int      err_count   = 0;
   int      edges_sent  = 0;
   bit      idle_on     = 1'b1;
   int      hold_cycles = 0;

   // behavioral copy of the graph stores
   logic [NV-1:0] adj_bits[NV];
   int            deg[NV];
   int            vcount_reg;

   // walk scratch
   int vorder[NV], low[NV], onst[NV], comp[NV], csize[NV];
   int wv[NV], wn[NV], pend[NV];
   int visit_cnt, comp_cnt, wp, pp;

   high_degree_cycle_vertex_search_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic void clear_graph();
      for (int i = 0; i < NV; i++) begin
         adj_bits[i] = '0;
         deg[i] = 0;
      end
   endfunction

   function automatic void enter_vertex(input int x);
      visit_cnt++;
      vorder[x] = visit_cnt;
      low[x] = visit_cnt;
      pend[pp] = x;
      pp++;
      onst[x] = 1;
      wv[wp] = x;
      wn[wp] = 0;
      wp++;
   endfunction

   // tarjan walk over the loaded graph, tree edges kept parent to child
   function automatic rsp_type search_graph(input int n);
      int top, x, c, y, p, w, id, hit;
      bit desc, done;
      rsp_type r;
      for (int i = 0; i < NV; i++) begin
         vorder[i] = 0; low[i] = 0; onst[i] = 0; comp[i] = 0; csize[i] = 0;
      end
      visit_cnt = 0; comp_cnt = 0; wp = 0; pp = 0;
      for (int root = 0; root < n; root++) begin
         if (vorder[root] != 0) continue;
         enter_vertex(root);
         while (wp > 0) begin
            top = wp - 1;
            x = wv[top];
            c = wn[top];
            desc = 1'b0;
            while (c < n && !desc) begin
               y = c;
               c++;
               if (adj_bits[x][y]) begin
                  if (vorder[y] == 0) begin
                     adj_bits[y][x] = 1'b0;
                     wn[top] = c;
                     enter_vertex(y);
                     desc = 1'b1;
                  end else if (onst[y] != 0 && vorder[y] < low[x]) begin
                     low[x] = vorder[y];
                  end
               end
            end
            if (!desc) begin
               wn[top] = c;
               // root of a component: pop it off the pending stack
               if (low[x] == vorder[x]) begin
                  id = comp_cnt % NV;
                  comp_cnt++;
                  done = 1'b0;
                  while (pp > 0 && !done) begin
                     pp--;
                     w = pend[pp];
                     onst[w] = 0;
                     comp[w] = id;
                     csize[id]++;
                     if (w == x) done = 1'b1;
                  end
               end
               wp--;
               if (wp > 0) begin
                  p = wv[wp-1];
                  if (low[x] < low[p]) low[p] = low[x];
               end
            end
         end
      end
      hit = 0;
      for (int i = 0; i < n; i++) begin
         if (deg[i] >= 4 && csize[comp[i]] > 2) begin
            hit = i + 1;
            break;
         end
      end
      r.found  = (hit != 0);
      r.vertex = FieldW'(hit);
      return r;
   endfunction

   // apply one accepted edge beat to the behavioral copy
   function automatic void load_edge(input req_type it);
      int n, u, v;
      n = (vcount_reg > NV) ? NV : vcount_reg;
      u = it.from_vertex;
      v = it.to_vertex;
      if (u >= 1 && u <= n && v >= 1 && v <= n) begin
         adj_bits[u-1][v-1] = 1'b1;
         adj_bits[v-1][u-1] = 1'b1;
         if (deg[u-1] < 4) deg[u-1]++;
         if (deg[v-1] < 4) deg[v-1]++;
      end
      if (it.last_edge) begin
         answer_q.insert(answer_q.size(), search_graph(n));
         clear_graph();
      end
   endfunction

   // send one edge beat and wait for it to be taken
   task automatic send_edge(input int u, input int v, input bit last);
      req_type it;
      it.from_vertex = FieldW'(u);
      it.to_vertex   = FieldW'(v);
      it.last_edge   = last;
      if (idle_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      load_edge(it);
      edges_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
   endtask

   // register write while the core is idle
   task automatic set_vertex_count(input int value);
      wait_drain();
      repeat (30) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= FieldW'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      vcount_reg = value;
   endtask

   // result side ready, with random idling and an optional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(99) < 7);
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_q.size() == 0) begin
            report_mismatch($sformatf("result with none expected: found=%0d vertex=%0d",
                                      rsp_data.found, rsp_data.vertex));
         end else begin
            exp_r = answer_q.pop_front();
            if (rsp_data.found !== exp_r.found)
               report_mismatch($sformatf("found %0d, expected %0d",
                                         rsp_data.found, exp_r.found));
            if (rsp_data.vertex !== exp_r.vertex)
               report_mismatch($sformatf("vertex %0d, expected %0d",
                                         rsp_data.vertex, exp_r.vertex));
         end
      end
   end

   // field extremes, self loop, repeats, out-of-range endpoints
   task automatic test_extremes();
      set_vertex_count(64);
      send_edge(64, 1, 0);
      send_edge(1, 2, 0);
      send_edge(2, 64, 0);
      send_edge(64, 63, 0);
      send_edge(64, 64, 0);
      send_edge(0, 5, 0);
      send_edge(65, 3, 0);
      send_edge(127, 127, 0);
      send_edge(1, 2, 1);
      send_edge(0, 0, 1);
      // pure bridge star: hub degree 4 but every component has one vertex
      send_edge(10, 11, 0);
      send_edge(10, 12, 0);
      send_edge(10, 13, 0);
      send_edge(10, 14, 1);
   endtask

   // register extremes: zero, one, above the vertex limit
   task automatic test_vertex_counts();
      set_vertex_count(0);
      send_edge(1, 1, 1);
      set_vertex_count(1);
      send_edge(1, 1, 0);
      send_edge(1, 1, 0);
      send_edge(1, 1, 1);
      set_vertex_count(127);
      send_edge(64, 63, 0);
      send_edge(63, 62, 0);
      send_edge(62, 64, 0);
      send_edge(64, 64, 1);
   endtask

   // register changed halfway through loading a graph
   task automatic test_count_change();
      set_vertex_count(5);
      send_edge(1, 2, 0);
      send_edge(2, 3, 0);
      send_edge(3, 1, 0);
      send_edge(1, 5, 0);
      send_edge(1, 4, 0);
      set_vertex_count(3);
      send_edge(1, 5, 0);
      send_edge(1, 3, 1);
   endtask

   // random graph of n vertices with some noise endpoints
   task automatic send_random_graph(input int n);
      int ne, u, v, hub;
      ne  = $urandom_range(1, 2 * n + 2);
      hub = $urandom_range(1, n);
      for (int k = 0; k < ne; k++) begin
         if ($urandom_range(99) < 5) begin
            u = $urandom_range(0, 127);
            v = $urandom_range(0, 127);
         end else begin
            // lean toward a hub so degree 4 is common
            u = ($urandom_range(99) < 40) ? hub : $urandom_range(1, n);
            v = $urandom_range(1, n);
         end
         send_edge(u, v, k == ne - 1);
      end
   endtask

   // receiver held off while several graphs are offered
   task automatic test_backpressure();
      set_vertex_count(6);
      hold_cycles <= 3000;
      for (int g = 0; g < 5; g++) send_random_graph(6);
      wait_drain();
   endtask

   task automatic test_random();
      int n;
      while (edges_sent < 1550) begin
         if ($urandom_range(99) < 8) n = ($urandom_range(1) != 0) ? 64 : 127;
         else n = $urandom_range(3, 12);
         set_vertex_count(n);
         // a calm stretch with no idling on either side
         idle_on = !(edges_sent > 700 && edges_sent < 950);
         send_random_graph((n > NV) ? NV : n);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      vcount_reg  = VertexCountReset;
      clear_graph();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_vertex_counts();
      test_count_change();
      test_backpressure();
      test_random();
      wait_drain();
      repeat (100) @(posedge clock);
      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
